// ----- hdl/object_file_section_parser_unit_macros.svh -----
// Assertion macros shared by the checker of the object file section parser unit.
`ifndef OBJECT_FILE_SECTION_PARSER_UNIT_MACROS_SVH
`define OBJECT_FILE_SECTION_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define OSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("object file section parser: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define OSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("object file section parser: next-cycle check failed");

`endif

// ----- hdl/osp_pkg.sv -----
// Shared types and constants of the object file section parser unit.
package osp_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_CODE     = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd1;
    localparam logic [1:0] KIND_CHAR     = 2'd2;
    localparam logic [1:0] KIND_COMPLETE = 2'd3;

    // Section header words.
    localparam logic [15:0] HDR_CODE     = 16'hCADE;
    localparam logic [15:0] HDR_DATA     = 16'hDADA;
    localparam logic [15:0] HDR_SYMBOL   = 16'hC3B7;
    localparam logic [15:0] HDR_FILENAME = 16'hF17E;
    localparam logic [15:0] HDR_LINE     = 16'h715E;

    // Default depth of the queue between front and back.
    localparam int OSP_QUEUE_DEPTH = 4;

    // One queued work entry; pair marks a character followed by its completion marker.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] value;
        logic        pair;
    } osp_entry_t;

endpackage

// ----- hdl/osp_front.sv -----
// Front part: accepts stream bytes, assembles words and tracks the section state.
module osp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] byte_in
    input  logic               q_full,
    output logic               push,
    output osp_pkg::osp_entry_t push_entry
);
    import osp_pkg::*;

    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_ADDR     = 3'd1;
    localparam logic [2:0] PH_COUNT    = 3'd2;
    localparam logic [2:0] PH_BODY     = 3'd3;
    localparam logic [2:0] PH_SYMCHARS = 3'd4;
    localparam logic [2:0] PH_SKIP     = 3'd5;

    localparam logic [2:0] SEC_CODE     = 3'd0;
    localparam logic [2:0] SEC_DATA     = 3'd1;
    localparam logic [2:0] SEC_SYMBOL   = 3'd2;
    localparam logic [2:0] SEC_FILENAME = 3'd3;
    localparam logic [2:0] SEC_LINE     = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  section_reg, section_next;
    logic [7:0]  hold_reg, hold_next;
    logic        odd_reg, odd_next;
    logic [15:0] base_reg, base_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] rem_reg, rem_next;

    logic        accept;
    logic [2:0]  eff_phase;
    logic        eff_odd;
    logic [15:0] word;
    logic        rem_last;

    // A byte is taken whenever the queue has a free slot.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign word     = {hold_reg, s_tdata};
    assign rem_last = (rem_reg == 16'd1);

    // Unused phase codes behave as the wait for a header word.
    assign eff_phase = (phase_reg > PH_SKIP) ? PH_HEADER : phase_reg;
    assign eff_odd   = (phase_reg > PH_SKIP) ? 1'b0 : odd_reg;

    // Next-state and queue entry for the accepted byte.
    always_comb
    begin
        phase_next   = phase_reg;
        section_next = section_reg;
        hold_next    = hold_reg;
        odd_next     = odd_reg;
        base_next    = base_reg;
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        push         = 1'b0;
        push_entry   = '0;
        if (accept)
        begin
            case (eff_phase)
                PH_SYMCHARS:
                begin
                    push             = 1'b1;
                    push_entry.kind  = KIND_CHAR;
                    push_entry.addr  = base_reg;
                    push_entry.value = {8'h00, s_tdata};
                    push_entry.pair  = rem_last;
                    rem_next         = rem_reg - 16'd1;
                    if (rem_last)
                    begin
                        phase_next = PH_HEADER;
                        odd_next   = 1'b0;
                    end
                end
                PH_SKIP:
                begin
                    rem_next = rem_reg - 16'd1;
                    if (rem_last)
                    begin
                        phase_next = PH_HEADER;
                        odd_next   = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = eff_phase;
                    if (!eff_odd)
                    begin
                        hold_next = s_tdata;
                        odd_next  = 1'b1;
                    end
                    else
                    begin
                        odd_next = 1'b0;
                        case (eff_phase)
                            PH_HEADER:
                            begin
                                if (word == HDR_CODE)
                                begin
                                    section_next = SEC_CODE;
                                    phase_next   = PH_ADDR;
                                end
                                else if (word == HDR_DATA)
                                begin
                                    section_next = SEC_DATA;
                                    phase_next   = PH_ADDR;
                                end
                                else if (word == HDR_SYMBOL)
                                begin
                                    section_next = SEC_SYMBOL;
                                    phase_next   = PH_ADDR;
                                end
                                else if (word == HDR_FILENAME)
                                begin
                                    section_next = SEC_FILENAME;
                                    phase_next   = PH_COUNT;
                                end
                                else if (word == HDR_LINE)
                                begin
                                    section_next = SEC_LINE;
                                    rem_next     = 16'd6;
                                    phase_next   = PH_SKIP;
                                end
                            end
                            PH_ADDR:
                            begin
                                base_next  = word;
                                cur_next   = word;
                                phase_next = PH_COUNT;
                            end
                            PH_COUNT:
                            begin
                                rem_next = word;
                                if (section_reg == SEC_SYMBOL)
                                begin
                                    if (word == 16'd0)
                                    begin
                                        push             = 1'b1;
                                        push_entry.kind  = KIND_COMPLETE;
                                        push_entry.addr  = base_reg;
                                        push_entry.value = 16'd0;
                                        push_entry.pair  = 1'b0;
                                        phase_next       = PH_HEADER;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SYMCHARS;
                                    end
                                end
                                else if (section_reg == SEC_FILENAME)
                                begin
                                    phase_next = (word == 16'd0) ? PH_HEADER : PH_SKIP;
                                end
                                else
                                begin
                                    phase_next = (word == 16'd0) ? PH_HEADER : PH_BODY;
                                end
                            end
                            default:
                            begin
                                // Body word of a code or data section.
                                push             = 1'b1;
                                push_entry.kind  = (section_reg == SEC_DATA) ? KIND_DATA
                                                                             : KIND_CODE;
                                push_entry.addr  = cur_reg;
                                push_entry.value = word;
                                push_entry.pair  = 1'b0;
                                cur_next         = cur_reg + 16'd1;
                                rem_next         = rem_reg - 16'd1;
                                if (rem_last)
                                begin
                                    phase_next = PH_HEADER;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Section state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            section_reg <= SEC_CODE;
            hold_reg    <= 8'h00;
            odd_reg     <= 1'b0;
            base_reg    <= 16'h0000;
            cur_reg     <= 16'h0000;
            rem_reg     <= 16'h0000;
        end
        else
        begin
            phase_reg   <= phase_next;
            section_reg <= section_next;
            hold_reg    <= hold_next;
            odd_reg     <= odd_next;
            base_reg    <= base_next;
            cur_reg     <= cur_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

// ----- hdl/osp_queue.sv -----
// Short queue of work entries between the front and back parts.
module osp_queue #(
    parameter int DEPTH = osp_pkg::OSP_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  osp_pkg::osp_entry_t push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output osp_pkg::osp_entry_t head
);
    import osp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    osp_entry_t    slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/osp_back.sv -----
// Back part: drains the queue and drives the result stream from an output register.
module osp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  osp_pkg::osp_entry_t q_head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [15:0] target_address, [31:16] value
    output logic [1:0]          m_tuser,   // [1:0] kind
    output logic                m_tlast    // last_of_run
);
    import osp_pkg::*;

    logic        valid_reg, valid_next;
    logic        pending_reg, pending_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] value_reg, value_next;
    logic        last_reg, last_next;
    logic        can_load;

    assign can_load = !valid_reg || m_tready;
    assign pop      = can_load && !pending_reg && !q_empty;

    // Load the next result: the completion half of a pair first, else the queue head.
    always_comb
    begin
        valid_next   = valid_reg;
        pending_next = pending_reg;
        kind_next    = kind_reg;
        addr_next    = addr_reg;
        value_next   = value_reg;
        last_next    = last_reg;
        if (can_load)
        begin
            if (pending_reg)
            begin
                valid_next   = 1'b1;
                pending_next = 1'b0;
                kind_next    = KIND_COMPLETE;
                value_next   = 16'd0;
                last_next    = 1'b1;
            end
            else if (!q_empty)
            begin
                valid_next   = 1'b1;
                pending_next = q_head.pair;
                kind_next    = q_head.kind;
                addr_next    = q_head.addr;
                value_next   = q_head.value;
                last_next    = !q_head.pair;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            pending_reg <= pending_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        addr_reg  <= addr_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {value_reg, addr_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- hdl/object_file_section_parser_unit.sv -----
// Top level of the object file section parser unit.
//
// The slave stream takes one object file byte per transaction in s_tdata[7:0].
// The master stream gives one result per transaction: m_tdata[15:0] is the
// target address, m_tdata[31:16] the value, m_tuser the result kind (code
// write, data write, symbol character, symbol complete) and m_tlast marks the
// final result caused by a byte. Bytes that cause no result give no transaction.
// A byte's result entry is pushed into the queue as the byte is accepted and is
// loaded into the output register once that is free. Input runs at one byte per
// cycle while the queue is not full; the last character byte of a symbol gives
// two results, which leave one after the other through the single output
// register. The front part writes into a QUEUE_DEPTH entry queue and s_tready
// falls only while that queue is full, so a stalled receiver fills the queue
// first and then stops the input. Reset clears the section state, the queue and
// the output valid flag; the next byte is the first byte of a header word.
module object_file_section_parser_unit #(
    parameter int QUEUE_DEPTH = osp_pkg::OSP_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] target_address, [31:16] value
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_of_run
);
    import osp_pkg::*;

    logic       q_full, q_empty, push, pop;
    osp_entry_t push_entry, q_head;

    osp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    osp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    osp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/osp_checker.sv -----
// Port-level checker of the object file section parser unit and its bind.
`include "object_file_section_parser_unit_macros.svh"

module osp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import osp_pkg::*;

    logic        out_stall;
    logic        out_split;
    logic        out_complete;
    logic [34:0] out_beat;

    // Views of the result channel used by the checks below.
    assign out_stall    = m_tvalid && !m_tready;
    assign out_split    = m_tvalid && m_tready && !m_tlast;
    assign out_complete = m_tvalid && (m_tuser == KIND_COMPLETE);
    assign out_beat     = {m_tlast, m_tuser, m_tdata};

    // A stalled result holds its payload.
    `OSP_ASSERT_NEXT(a_stall_hold, out_stall, m_tvalid && $stable(out_beat))

    // A completion marker carries value zero and ends its run.
    `OSP_ASSERT_SAME(a_complete_form, out_complete, m_tlast && (m_tdata[31:16] == 16'd0))

    // Only a symbol character can be followed by another result of the same byte.
    `OSP_ASSERT_SAME(a_non_last_char, m_tvalid && !m_tlast, m_tuser == KIND_CHAR)

    // The completion marker follows its character at once, at the same address.
    `OSP_ASSERT_NEXT(a_pair_follow, out_split, out_complete && $stable(m_tdata[15:0]))

endmodule

bind object_file_section_parser_unit osp_checker u_osp_checker (.*);
